// ===== hdl/sha1_pkg.sv =====
package sha1_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // one queued beat from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } sha1_item_t;

endpackage

// ===== hdl/sha1_in_if.sv =====
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    modport source (output valid, output data_byte, output has_byte, output last, input ready);
    modport sink (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

// ===== hdl/sha1_out_if.sv =====
interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// ===== hdl/sha1_front.sv =====
module sha1_front
(
    input  logic                clk,
    input  logic                rst_n,
    sha1_in_if.sink             in_ch,
    output sha1_pkg::sha1_item_t q_item,
    output logic                q_valid,
    input  logic                q_pop
);
    // two-entry queue, drops idle beats
    sha1_pkg::sha1_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.last);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{in_ch.data_byte, in_ch.has_byte, in_ch.last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !in_ch.ready) else $error("ready while full");
endmodule

// ===== hdl/sha1_back.sv =====
module sha1_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha1_pkg::sha1_item_t q_item,
    input  logic                 q_valid,
    output logic                 q_pop,
    sha1_out_if.source           out_ch
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_ROUND = 6'b000100,
        S_FOLD  = 6'b001000,
        S_LEN   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] h_reg [5];
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  t_reg;
    logic [60:0] cnt_reg;
    logic [5:0]  pos_reg;      // byte position of padding fill
    logic        fin_reg;      // compressing within final padding
    logic        two_reg;      // length block still to go
    logic        pad_reg;      // block with the pad byte still to go
    logic [2:0]  oidx_reg;

    logic [31:0] f, k, tmp, wnew, wcur;
    logic [5:0]  pos;
    logic [5:0]  pad_pos;
    logic [63:0] bit_len;

    assign pos = cnt_reg[5:0];
    assign pad_pos = q_item.has_byte ? pos + 6'd1 : pos;
    assign bit_len = {cnt_reg, 3'b000};

    always_comb
    begin
        wnew = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wnew = {wnew[30:0], wnew[31]};
        wcur = (t_reg < 7'd16) ? w_reg[0] : wnew;
        if (t_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1_pkg::K0;
        end
        else if (t_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K1;
        end
        else if (t_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1_pkg::K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K3;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wcur;
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.digest_word = h_reg[oidx_reg];
    assign out_ch.word_index = oidx_reg;
    assign out_ch.last_word = (oidx_reg == 3'd4);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.has_byte && (pos == 6'd63))
                    begin
                        state_next = S_ROUND;
                    end
                    else if (q_item.last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:   state_next = (pos_reg == 6'd63) ? S_ROUND : S_PAD;
            S_ROUND: state_next = (t_reg == 7'd79) ? S_FOLD : S_ROUND;
            S_FOLD:
            begin
                if (two_reg)
                begin
                    state_next = S_LEN;
                end
                else if (pad_reg)
                begin
                    state_next = S_PAD;
                end
                else if (fin_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LEN:   state_next = (pos_reg == 6'd63) ? S_ROUND : S_LEN;
            S_OUT:   state_next = (out_ch.ready && oidx_reg == 3'd4) ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            h_reg     <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3,
                           sha1_pkg::H4};
            cnt_reg   <= '0;
            t_reg     <= '0;
            pos_reg   <= '0;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    t_reg <= '0;
                    if (q_valid)
                    begin
                        if (q_item.has_byte)
                        begin
                            cnt_reg <= cnt_reg + 61'd1;
                        end
                        pos_reg <= pad_pos;
                        fin_reg <= q_item.last;
                        pad_reg <= q_item.last;
                        two_reg <= q_item.last && (pad_pos >= 6'd56);
                    end
                end
                S_PAD:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        pad_reg <= 1'b0;
                    end
                end
                S_ROUND:
                begin
                    t_reg <= t_reg + 7'd1;
                end
                S_FOLD:
                begin
                    t_reg    <= '0;
                    two_reg  <= 1'b0;
                    pos_reg  <= '0;
                    oidx_reg <= '0;
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                end
                S_LEN:
                begin
                    pos_reg <= pos_reg + 6'd1;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd4)
                        begin
                            h_reg   <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2,
                                         sha1_pkg::H3, sha1_pkg::H4};
                            cnt_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // block words shift in bytes at the tail and rotate out at the head during rounds
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wcur;
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
            if ((state_reg == S_IDLE && q_valid && q_item.has_byte) || state_reg == S_PAD ||
                state_reg == S_LEN)
            begin
                logic [7:0] nb;
                if (state_reg == S_IDLE)
                begin
                    nb = q_item.data_byte;
                end
                else if (state_reg == S_PAD && pos_reg == pos)
                begin
                    nb = sha1_pkg::PAD_BYTE;
                end
                else if (!two_reg && pos_reg >= 6'd56)
                begin
                    // bit length fills the last eight bytes, most significant first
                    nb = bit_len[{~pos_reg[2:0], 3'b000} +: 8];
                end
                else
                begin
                    nb = 8'h00;
                end
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
                end
                w_reg[15] <= {w_reg[15][23:0], nb};
            end
        end
    end

    a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> fin_reg) else $error("digest without last beat");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (t_reg < 7'd80)) else $error("round counter overrun");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE)) else $error("pop while busy");
endmodule

// ===== hdl/sha1_message_digest_unit.sv =====
// SHA-1 over a byte stream, one byte per input beat. A front queue of two beats takes bytes
// while the back compresses. Every 64th byte starts an 80-round compression at one round per
// cycle. A last beat adds one or two padding blocks, each a fill followed by a compression,
// then five digest beats, most significant first.
module sha1_message_digest_unit
(
    input  logic       clk,
    input  logic       rst_n,
    sha1_in_if.sink    in_ch,
    sha1_out_if.source out_ch
);
    sha1_pkg::sha1_item_t q_item;
    logic                 q_valid, q_pop;

    sha1_front u_front (.clk, .rst_n, .in_ch, .q_item, .q_valid, .q_pop);
    sha1_back  u_back  (.clk, .rst_n, .q_item, .q_valid, .q_pop, .out_ch);
endmodule
